>>> hdl/acrp_pkg.sv
package acrp_pkg;

  localparam int DATA_W      = 8;
  localparam int LEN_W       = 16;
  localparam int FIELD_W     = 4;
  localparam int CLASS_W     = 2;
  localparam int INDEX_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 32;
  localparam int M_TUSER_W   = 3;

  // Profiles that carry the extension part of the record.
  localparam logic [7:0] PROFILE_HIGH    = 8'd100;
  localparam logic [7:0] PROFILE_HIGH10  = 8'd110;
  localparam logic [7:0] PROFILE_HIGH422 = 8'd122;
  localparam logic [7:0] PROFILE_HIGH444 = 8'd144;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_SET_LEN   = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_TRUNCATED = 3'd4
  } kind_t;

  typedef enum logic [FIELD_W-1:0] {
    FID_VERSION   = 4'd0,
    FID_PROFILE   = 4'd1,
    FID_COMPAT    = 4'd2,
    FID_LEVEL     = 4'd3,
    FID_LENSIZE   = 4'd4,
    FID_CHROMA    = 4'd5,
    FID_LUMA      = 4'd6,
    FID_CDEPTH    = 4'd7,
    FID_SPS_COUNT = 4'd8,
    FID_PPS_COUNT = 4'd9,
    FID_EXT_COUNT = 4'd10
  } field_id_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_SPS     = 2'd0,
    CLASS_PPS     = 2'd1,
    CLASS_SPS_EXT = 2'd2
  } set_class_t;

  typedef enum logic [4:0] {
    PH_VERSION  = 5'd0,
    PH_PROFILE  = 5'd1,
    PH_COMPAT   = 5'd2,
    PH_LEVEL    = 5'd3,
    PH_LENSIZE  = 5'd4,
    PH_SPSCOUNT = 5'd5,
    PH_LENHI    = 5'd6,
    PH_LENLO    = 5'd7,
    PH_PAYLOAD  = 5'd8,
    PH_PPSCOUNT = 5'd9,
    PH_CHROMA   = 5'd10,
    PH_LUMA     = 5'd11,
    PH_CDEPTH   = 5'd12,
    PH_EXTCOUNT = 5'd13,
    PH_SKIP     = 5'd14
  } phase_t;

  typedef struct packed {
    kind_t                  kind;
    field_id_t              field_id;
    logic [LEN_W-1:0]       value;
    set_class_t             set_class;
    logic [INDEX_W-1:0]     set_index;
    logic                   set_last_byte;
  } result_t;

  // What one input byte leaves for the back end: its own result, and the
  // closing result when the byte ends the record.
  typedef struct packed {
    logic    has_main;
    logic    has_end;
    logic    end_done;
    result_t main;
  } entry_t;

endpackage

>>> hdl/avc_config_record_parser.sv
// channel | dir | tdata                       | tuser    | tlast
// s_*     | in  | [7:0] data_byte             | -        | record_end
// m_*     | out | [3:0] field_id, [19:4]      | [2:0]    | set_last_byte
//         |     | value, [21:20] set_class,   | kind     |
//         |     | [29:22] set_index, [31:30] 0|          |
//
// A byte is accepted in any cycle the queue has room and updates the parse state
// at that edge; its words, if any, enter the queue and reach m_* behind older entries.
// A length high byte or an ignored tail byte gives no word unless it ends the
// record; the closing word follows the byte's own word.
// s_tready drops only when all QDEPTH entries wait on the output port.
// rst is synchronous and clears parse state and queue pointers.
module avc_config_record_parser
  import acrp_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // record_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // field_id, value, set_class, set_index, pad
  output logic [M_TUSER_W-1:0] m_tuser,   // kind
  output logic                 m_tlast    // set_last_byte
);

  logic    push;
  entry_t  push_entry;
  logic    queue_full;
  logic    head_valid;
  entry_t  head;
  logic    pop;
  result_t out_res;

  // Classify each byte against the parse phase and build its queue entry.
  acrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata[DATA_W-1:0]),
    .in_end     (s_tlast),
    .queue_full (queue_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  acrp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (head_valid),
    .head       (head)
  );

  // Drain entries: main word first, then the closing word if any.
  acrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_res    (out_res),
    .pop        (pop)
  );

  assign m_tdata = {2'b00, out_res.set_index, out_res.set_class, out_res.value,
                    out_res.field_id};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.set_last_byte;

endmodule

>>> hdl/acrp_front.sv
module acrp_front
  import acrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_end,
  input  logic              queue_full,
  output logic              in_ready,
  output logic              push,
  output entry_t            push_entry
);

  phase_t                 parse_phase, parse_phase_next;
  logic [7:0]             profile_seen, profile_seen_next;
  logic [7:0]             sets_remaining, sets_remaining_next;
  logic [INDEX_W-1:0]     current_index, current_index_next;
  logic [LEN_W-1:0]       bytes_remaining, bytes_remaining_next;
  logic [7:0]             length_high, length_high_next;
  set_class_t             current_class, current_class_next;
  logic                   ext_profile;
  logic                   accept;
  logic [LEN_W-1:0]       set_len;
  logic                   pay_last;
  entry_t                 entry;

  function automatic phase_t after_array(set_class_t cls, logic rec_end, logic ext);
    phase_t ph;
    if (cls == CLASS_SPS) begin
      ph = PH_PPSCOUNT;
    end else if (cls == CLASS_PPS && !rec_end && ext) begin
      ph = PH_CHROMA;
    end else begin
      ph = PH_SKIP;
    end
    return ph;
  endfunction

  assign ext_profile = (profile_seen == PROFILE_HIGH) || (profile_seen == PROFILE_HIGH10) ||
                       (profile_seen == PROFILE_HIGH422) || (profile_seen == PROFILE_HIGH444);
  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign set_len    = {length_high, in_byte};
  assign pay_last   = (bytes_remaining <= LEN_W'(1));
  assign push       = accept && (entry.has_main || entry.has_end);
  assign push_entry = entry;

  always_comb begin
    parse_phase_next     = parse_phase;
    profile_seen_next    = profile_seen;
    sets_remaining_next  = sets_remaining;
    current_index_next   = current_index;
    bytes_remaining_next = bytes_remaining;
    length_high_next     = length_high;
    current_class_next   = current_class;
    entry                = '0;
    entry.main.kind      = KIND_HEADER;

    case (parse_phase)
      PH_VERSION: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_VERSION;
        entry.main.value     = LEN_W'(in_byte);
        parse_phase_next     = PH_PROFILE;
      end
      PH_PROFILE: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_PROFILE;
        entry.main.value     = LEN_W'(in_byte);
        profile_seen_next    = in_byte;
        parse_phase_next     = PH_COMPAT;
      end
      PH_COMPAT: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_COMPAT;
        entry.main.value     = LEN_W'(in_byte);
        parse_phase_next     = PH_LEVEL;
      end
      PH_LEVEL: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_LEVEL;
        entry.main.value     = LEN_W'(in_byte);
        parse_phase_next     = PH_LENSIZE;
      end
      PH_LENSIZE: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_LENSIZE;
        entry.main.value     = LEN_W'(in_byte[1:0]);
        parse_phase_next     = PH_SPSCOUNT;
      end
      PH_SPSCOUNT: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_SPS_COUNT;
        entry.main.value     = LEN_W'(in_byte[4:0]);
        current_class_next   = CLASS_SPS;
        sets_remaining_next  = {3'b000, in_byte[4:0]};
        current_index_next   = '0;
        parse_phase_next     = (in_byte[4:0] == 5'd0) ?
                               after_array(CLASS_SPS, in_end, ext_profile) : PH_LENHI;
      end
      PH_LENHI: begin
        length_high_next     = in_byte;
        parse_phase_next     = PH_LENLO;
      end
      PH_LENLO: begin
        entry.has_main       = 1'b1;
        entry.main.kind      = KIND_SET_LEN;
        entry.main.value     = set_len;
        entry.main.set_class = current_class;
        entry.main.set_index = current_index;
        bytes_remaining_next = set_len;
        if (set_len == '0) begin
          sets_remaining_next = sets_remaining - 8'd1;
          current_index_next  = current_index + INDEX_W'(1);
          parse_phase_next    = (sets_remaining_next == 8'd0) ?
                                after_array(current_class, in_end, ext_profile) : PH_LENHI;
        end else begin
          parse_phase_next    = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        entry.has_main           = 1'b1;
        entry.main.kind          = KIND_PAYLOAD;
        entry.main.value         = LEN_W'(in_byte);
        entry.main.set_class     = current_class;
        entry.main.set_index     = current_index;
        entry.main.set_last_byte = pay_last;
        bytes_remaining_next     = bytes_remaining - LEN_W'(1);
        if (pay_last) begin
          sets_remaining_next = sets_remaining - 8'd1;
          current_index_next  = current_index + INDEX_W'(1);
          parse_phase_next    = (sets_remaining_next == 8'd0) ?
                                after_array(current_class, in_end, ext_profile) : PH_LENHI;
        end
      end
      PH_PPSCOUNT: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_PPS_COUNT;
        entry.main.value     = LEN_W'(in_byte);
        current_class_next   = CLASS_PPS;
        sets_remaining_next  = in_byte;
        current_index_next   = '0;
        parse_phase_next     = (in_byte == 8'd0) ?
                               after_array(CLASS_PPS, in_end, ext_profile) : PH_LENHI;
      end
      PH_CHROMA: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_CHROMA;
        entry.main.value     = LEN_W'(in_byte[1:0]);
        parse_phase_next     = PH_LUMA;
      end
      PH_LUMA: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_LUMA;
        entry.main.value     = LEN_W'(in_byte[2:0]);
        parse_phase_next     = PH_CDEPTH;
      end
      PH_CDEPTH: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_CDEPTH;
        entry.main.value     = LEN_W'(in_byte[2:0]);
        parse_phase_next     = PH_EXTCOUNT;
      end
      PH_EXTCOUNT: begin
        entry.has_main       = 1'b1;
        entry.main.field_id  = FID_EXT_COUNT;
        entry.main.value     = LEN_W'(in_byte);
        current_class_next   = CLASS_SPS_EXT;
        sets_remaining_next  = in_byte;
        current_index_next   = '0;
        parse_phase_next     = (in_byte == 8'd0) ?
                               after_array(CLASS_SPS_EXT, in_end, ext_profile) : PH_LENHI;
      end
      default: begin
        parse_phase_next = PH_SKIP;
      end
    endcase

    // Close the record: done only when the parse reached its tail.
    if (in_end) begin
      entry.has_end        = 1'b1;
      entry.end_done       = (parse_phase_next == PH_SKIP);
      parse_phase_next     = PH_VERSION;
      profile_seen_next    = '0;
      sets_remaining_next  = '0;
      current_index_next   = '0;
      bytes_remaining_next = '0;
      length_high_next     = '0;
      current_class_next   = CLASS_SPS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_VERSION;
      profile_seen    <= '0;
      sets_remaining  <= '0;
      current_index   <= '0;
      bytes_remaining <= '0;
      length_high     <= '0;
      current_class   <= CLASS_SPS;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      profile_seen    <= profile_seen_next;
      sets_remaining  <= sets_remaining_next;
      current_index   <= current_index_next;
      bytes_remaining <= bytes_remaining_next;
      length_high     <= length_high_next;
      current_class   <= current_class_next;
    end
  end

endmodule

>>> hdl/acrp_queue.sv
module acrp_queue
  import acrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         store [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/acrp_back.sv
module acrp_back
  import acrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  entry_t  head,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res,
  output logic    pop
);

  logic main_sent;
  logic show_main;
  logic take;

  assign show_main = head.has_main && !main_sent;
  assign out_valid = head_valid;
  assign take      = head_valid && out_ready;
  // Hold the entry while its closing word still waits behind the main one.
  assign pop       = take && !(show_main && head.has_end);

  always_comb begin
    if (show_main) begin
      out_res = head.main;
    end else begin
      out_res      = '0;
      out_res.kind = head.end_done ? KIND_DONE : KIND_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_sent <= 1'b0;
    end else if (take) begin
      main_sent <= !pop;
    end
  end

endmodule
